[hw/rtl/lkvc_pkg.sv]
// lkvc_pkg: shared constants, types and helpers for the LRU key-value cache.
// No dependencies; imported by every module of the block.
package lkvc_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RANK_W  = IDX_W;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned KIND_W  = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    RESP_PUT_DONE = 2'd0,
    RESP_GET_HIT  = 2'd1,
    RESP_GET_MISS = 2'd2
  } resp_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DECIDE,
    ST_EVICT,
    ST_INSERT,
    ST_TOUCH,
    ST_RESP
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic start;      // latch request, reset scan
    logic look;       // step the key scan
    logic cnt_clr;    // restart the slot counter
    logic evict_try;  // test slot under counter for eviction
    logic insert;     // age all valid entries, write new key into free slot
    logic touch;      // make hit slot most recent, write value on put
    logic resp_load;  // load output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic look_done;
    logic hit;
    logic is_put;
    logic need_evict;
    logic evict_hit;
    logic occ_m1_ge_cap;
    logic out_free;
  } dp_status_t;

  // Clamp the raw capacity to 1..ENTRIES.
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] raw);
    logic [CNT_W-1:0] c;
    c = CNT_W'(raw);
    if (raw == '0) begin
      c = CNT_W'(1);
    end else if (32'(raw) > ENTRIES) begin
      c = CNT_W'(ENTRIES);
    end
    return c;
  endfunction

endpackage

[hw/rtl/lkvc_ctrl.sv]
// lkvc_ctrl: request sequencer of the LRU key-value cache.
// Depends on lkvc_pkg; drives lkvc_datapath through dp_cmd_t / dp_status_t.
module lkvc_ctrl import lkvc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (status_i.look_done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status_i.hit) begin
          state_d = ST_TOUCH;
        end else if (!status_i.is_put) begin
          state_d = ST_RESP;
        end else if (status_i.need_evict) begin
          state_d = ST_EVICT;
        end else begin
          state_d = ST_INSERT;
        end
      end
      ST_EVICT: begin
        if (status_i.evict_hit && !status_i.occ_m1_ge_cap) state_d = ST_INSERT;
      end
      ST_INSERT: state_d = ST_RESP;
      ST_TOUCH:  state_d = ST_RESP;
      ST_RESP: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.start = in_valid_i;
      end
      ST_LOOK:   cmd_o.look = 1'b1;
      ST_DECIDE: cmd_o.cnt_clr = 1'b1;
      ST_EVICT:  cmd_o.evict_try = 1'b1;
      ST_INSERT: cmd_o.insert = 1'b1;
      ST_TOUCH:  cmd_o.touch = 1'b1;
      ST_RESP:   cmd_o.resp_load = status_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[hw/rtl/lkvc_datapath.sv]
// lkvc_datapath: key/value memories, valid bits, recency ranks, occupancy,
// capacity and the output register. Depends on lkvc_pkg.
module lkvc_datapath import lkvc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  input  logic               req_type_i,
  input  logic [KEY_W-1:0]   lookup_key_i,
  input  logic [VAL_W-1:0]   put_value_i,
  input  logic               cfg_we_i,
  input  logic [CAP_W-1:0]   cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [KIND_W-1:0]  resp_kind_o,
  output logic [VAL_W-1:0]   read_value_o
);

  logic [KEY_W-1:0] key_mem [ENTRIES];
  logic [VAL_W-1:0] val_mem [ENTRIES];

  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic              is_put_q;

  logic [CNT_W-1:0]  cnt_q;
  logic [IDX_W-1:0]  cnt_idx;
  logic              cnt_end;

  logic              cmp_en_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic [KEY_W-1:0]  key_rd_q;
  logic [VAL_W-1:0]  val_rd_q;

  logic              hit_q;
  logic [IDX_W-1:0]  slot_q;
  logic [VAL_W-1:0]  hit_val_q;
  logic              free_found_q;
  logic [IDX_W-1:0]  free_q;

  logic [ENTRIES-1:0] valid_q;
  logic [RANK_W-1:0]  rank_q [ENTRIES];
  logic [CNT_W-1:0]   occ_q;
  logic [CNT_W-1:0]   occ_m1;
  logic [CNT_W-1:0]   cap_q;

  logic [IDX_W-1:0]  rsel;
  logic [RANK_W-1:0] rank_sel;
  logic              evict_match;
  logic              cmp_match;

  logic              out_valid_q;
  resp_kind_e        resp_kind_q;
  logic [VAL_W-1:0]  read_value_q;

  assign cnt_idx  = cnt_q[IDX_W-1:0];
  assign cnt_end  = (cnt_q == CNT_W'(ENTRIES));
  assign occ_m1   = occ_q - CNT_W'(1);
  assign rsel     = cmd_i.touch ? slot_q : cnt_idx;
  assign rank_sel = rank_q[rsel];

  assign evict_match = valid_q[rsel] && (rank_sel == occ_m1[RANK_W-1:0]);
  assign cmp_match   = valid_q[cmp_idx_q] && (key_rd_q == key_q);

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q    <= lookup_key_i;
      val_q    <= put_value_i;
      is_put_q <= (req_type_i == REQ_PUT);
    end
  end

  // memories: one registered read at the scan address, one write port each
  always_ff @(posedge clk_i) begin
    key_rd_q  <= key_mem[cnt_idx];
    val_rd_q  <= val_mem[cnt_idx];
    cmp_idx_q <= cnt_idx;
    if (cmd_i.insert) begin
      key_mem[free_q] <= key_q;
      val_mem[free_q] <= val_q;
    end else if (cmd_i.touch && is_put_q) begin
      val_mem[slot_q] <= val_q;
    end
  end

  // scan counter, compare stage, hit and free slot tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      cmp_en_q     <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      cmp_en_q <= cmd_i.look && !cnt_end;
      if (cmd_i.start || cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.look && !cnt_end) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.evict_try) begin
        if (evict_match || cnt_idx == IDX_W'(ENTRIES - 1)) begin
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      if (cmd_i.start) begin
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
      end else if (cmp_en_q) begin
        if (cmp_match) hit_q <= 1'b1;
        if (!valid_q[cmp_idx_q]) free_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_en_q && cmp_match) begin
      slot_q    <= cmp_idx_q;
      hit_val_q <= val_rd_q;
    end
    if (cmd_i.evict_try && evict_match) begin
      free_q <= cnt_idx;
    end else if (cmp_en_q && !valid_q[cmp_idx_q] && !free_found_q) begin
      free_q <= cmp_idx_q;
    end
  end

  // valid bits, recency ranks, occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.evict_try && evict_match) begin
      valid_q[cnt_idx] <= 1'b0;
      rank_q[cnt_idx]  <= '0;
      occ_q            <= occ_m1;
    end else if (cmd_i.insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i]) rank_q[i] <= rank_q[i] + RANK_W'(1);
      end
      valid_q[free_q] <= 1'b1;
      rank_q[free_q]  <= '0;
      occ_q           <= occ_q + CNT_W'(1);
    end else if (cmd_i.touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && rank_q[i] < rank_sel) rank_q[i] <= rank_q[i] + RANK_W'(1);
      end
      rank_q[slot_q] <= '0;
    end
  end

  // capacity register, stored already clamped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= eff_cap(CAP_RESET);
    end else if (cfg_we_i) begin
      cap_q <= eff_cap(cfg_wdata_i);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.resp_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_load) begin
      if (is_put_q) begin
        resp_kind_q  <= RESP_PUT_DONE;
        read_value_q <= '0;
      end else if (hit_q) begin
        resp_kind_q  <= RESP_GET_HIT;
        read_value_q <= hit_val_q;
      end else begin
        resp_kind_q  <= RESP_GET_MISS;
        read_value_q <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign resp_kind_o  = resp_kind_q;
  assign read_value_o = read_value_q;

  assign status_o.look_done     = cnt_end;
  assign status_o.hit           = hit_q;
  assign status_o.is_put        = is_put_q;
  assign status_o.need_evict    = (occ_q >= cap_q);
  assign status_o.evict_hit     = evict_match;
  assign status_o.occ_m1_ge_cap = (occ_m1 >= cap_q);
  assign status_o.out_free      = !out_valid_q || !out_stall_i;

endmodule

[hw/rtl/lru_key_value_cache_top.sv]
// lru_key_value_cache_top: top level of the LRU key-value cache.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath.
//
// A key-value table of ENTRIES (16) slots kept in least-recently-used order.
// One request transaction (get or put) is taken at a time and answered by
// exactly one result transaction: resp_kind 0 = put done, 1 = get hit (with
// the stored value), 2 = get miss (read_value is zero for put and miss).
// Lookup: a key lookup scans the key memory through its single registered
// read port, one slot per cycle, and every request scans all ENTRIES slots.
// A put on a new key with the table at capacity first evicts the least
// recent entry (the eviction search walks the rank registers one slot per
// cycle); if the capacity was lowered below the current fill, it evicts
// entries until the fill is below the capacity. Input stall is high from
// accept until the result is loaded into the output register; a result
// waiting there does not block the next request. Capacity (1..16, 0 acts as
// 1, above ENTRIES saturates) is written through cfg_we_i / cfg_wdata_i; the
// user must write it only while idle, the block itself does not enforce this.
// The table is empty after reset; no clearing pass is needed.
module lru_key_value_cache_top import lkvc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [KEY_W-1:0]   lookup_key_i,
  input  logic [VAL_W-1:0]   put_value_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [KIND_W-1:0]  resp_kind_o,
  output logic [VAL_W-1:0]   read_value_o,
  // capacity register
  input  logic               cfg_we_i,
  input  logic [CAP_W-1:0]   cfg_wdata_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  lkvc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lkvc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .req_type_i   (req_type_i),
    .lookup_key_i (lookup_key_i),
    .put_value_i  (put_value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .resp_kind_o  (resp_kind_o),
    .read_value_o (read_value_o)
  );

endmodule

[hw/rtl/lkvc_port_chk.sv]
// lkvc_port_chk: port-level assertions for the LRU key-value cache, and the
// bind that attaches them to lru_key_value_cache_top. Depends on lkvc_pkg.
module lkvc_port_chk import lkvc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [KIND_W-1:0] resp_kind_o,
  input logic [VAL_W-1:0]  read_value_o
);

  // one transaction in flight: an accepted request blocks the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while previous one still in progress");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (resp_kind_o == RESP_PUT_DONE || resp_kind_o == RESP_GET_HIT ||
                     resp_kind_o == RESP_GET_MISS))
    else $error("illegal response kind");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && resp_kind_o != RESP_GET_HIT) |-> (read_value_o == '0))
    else $error("nonzero read value on put or miss");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(resp_kind_o) && $stable(read_value_o)))
    else $error("stalled result changed");

endmodule

bind lru_key_value_cache_top lkvc_port_chk u_port_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .resp_kind_o  (resp_kind_o),
  .read_value_o (read_value_o)
);

[verif/tb.sv]
// tb: self-checking testbench for lru_key_value_cache_top.
// Depends on lkvc_pkg (widths, request codes, result kinds) and the cache RTL;
// a scoreboard class predicts every result with its own model of the LRU table.
`timescale 1ns / 1ps

module tb;
  import lkvc_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int STALL_LIMIT  = 3000;  // cycles with no transaction on any channel
  localparam int PRESSURE_AT  = 80;    // request count that triggers the long hold
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES  = 60;
  localparam int NUM_PHASES   = 6;

  typedef struct packed {
    resp_kind_e       kind;
    logic [VAL_W-1:0] value;
  } cache_result_t;

  // Predicts the table contents and recency order, and holds the results
  // still owed by the block, oldest first.
  class lru_scoreboard;
    logic [KEY_W-1:0]  slot_key[ENTRIES];
    logic [VAL_W-1:0]  slot_value[ENTRIES];
    bit                slot_used[ENTRIES];
    logic [RANK_W-1:0] slot_rank[ENTRIES];
    logic [CNT_W-1:0]  fill;
    logic [CAP_W-1:0]  capacity_reg;
    cache_result_t     results_due[$];
    int                errors;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_rank[i] = '0;
      end
      fill         = '0;
      capacity_reg = CAP_RESET;
      errors       = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] raw);
      capacity_reg = raw;
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    // Everything more recent than the slot ages by one; the slot becomes rank 0.
    function void promote(int slot);
      logic [RANK_W-1:0] r;
      r = slot_rank[slot];
      foreach (slot_used[i]) begin
        if (slot_used[i] && slot_rank[i] < r) slot_rank[i]++;
      end
      slot_rank[slot] = '0;
    endfunction

    function void note_request(logic req, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
      int            hit;
      int            limit;
      bit            dropped;
      bit            placed;
      cache_result_t res;
      hit = -1;
      foreach (slot_used[i]) begin
        if (slot_used[i] && slot_key[i] == key) hit = i;
      end
      res.kind  = RESP_PUT_DONE;
      res.value = '0;
      if (req == REQ_GET) begin
        if (hit >= 0) begin
          promote(hit);
          res.kind  = RESP_GET_HIT;
          res.value = slot_value[hit];
        end else begin
          res.kind = RESP_GET_MISS;
        end
      end else if (hit >= 0) begin
        // update in place, never evicts
        slot_value[hit] = val;
        promote(hit);
      end else begin
        // zero acts as one, anything past the table size saturates
        if (capacity_reg == '0) limit = 1;
        else if (capacity_reg > ENTRIES) limit = ENTRIES;
        else limit = capacity_reg;
        // capacity may have been lowered below the fill: drop oldest until it fits
        dropped = 1'b1;
        while (fill >= limit && dropped) begin
          dropped = 1'b0;
          foreach (slot_used[i]) begin
            if (!dropped && slot_used[i] && slot_rank[i] == fill - 1'b1) begin
              slot_used[i] = 1'b0;
              slot_rank[i] = '0;
              fill--;
              dropped = 1'b1;
            end
          end
        end
        foreach (slot_used[i]) begin
          if (slot_used[i]) slot_rank[i]++;
        end
        placed = 1'b0;
        foreach (slot_used[i]) begin
          if (!placed && !slot_used[i]) begin
            slot_used[i]  = 1'b1;
            slot_key[i]   = key;
            slot_value[i] = val;
            slot_rank[i]  = '0;
            fill++;
            placed = 1'b1;
          end
        end
      end
      results_due.push_back(res);
    endfunction

    function void check_result(logic [KIND_W-1:0] kind, logic [VAL_W-1:0] value);
      cache_result_t want;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction: kind %0d value %h",
                 $time, kind, value);
        return;
      end
      want = results_due.pop_front();
      if (kind !== want.kind) begin
        errors++;
        $display("%0t: resp_kind mismatch: expected %0d actual %0d",
                 $time, want.kind, kind);
      end
      if (value !== want.value) begin
        errors++;
        $display("%0t: read_value mismatch: expected %h actual %h",
                 $time, want.value, value);
      end
    endfunction
  endclass

  // Every input starts at a known value.
  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              req_type_i   = REQ_GET;
  logic [KEY_W-1:0]  lookup_key_i = '0;
  logic [VAL_W-1:0]  put_value_i  = '0;
  logic              out_stall_i  = 1'b0;
  logic              cfg_we_i     = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata_i  = '0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [KIND_W-1:0] resp_kind_o;
  logic [VAL_W-1:0]  read_value_o;

  lru_scoreboard store;
  int            req_count     = 0;  // accepted request transactions
  int            quiet_cycles  = 0;  // cycles since the last transaction
  int            idle_pct      = 20; // idle burst chance in %, per cycle or request
  bit            pressure_done = 1'b0;

  lru_key_value_cache_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .lookup_key_i (lookup_key_i),
    .put_value_i  (put_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .resp_kind_o  (resp_kind_o),
    .read_value_o (read_value_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Monitor: everything is sampled at the rising edge, before the block's
  // registers move. Results are checked before the request of the same edge
  // is noted, since a result can only belong to an older request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) store.check_result(resp_kind_o, read_value_o);
      if (in_valid_i && !in_stall_o) begin
        store.note_request(req_type_i, lookup_key_i, put_value_i);
        req_count++;
      end
      if (cfg_we_i) store.set_capacity(cfg_wdata_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // Watchdog: a hung handshake ends the run.
  initial begin : watchdog
    wait (rst_ni);
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  // Result side. Random stall bursts, plus one long hold while requests keep
  // coming so that the output register fills and the block stalls its input.
  initial begin : result_sink
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!pressure_done && req_count >= PRESSURE_AT) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i   <= 1'b0;
        pressure_done = 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offers one request transaction and returns at the falling edge after it
  // was taken. Valid stays high so back-to-back requests need no gap; the
  // caller lowers it before any configuration write.
  task automatic send_request(input logic req, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] val);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    lookup_key_i <= key;
    put_value_i  <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Capacity writes happen only with the block idle: nothing owed, no request.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    in_valid_i <= 1'b0;
    while (store.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [KEY_W-1:0] key_pool[32];
    logic [KEY_W-1:0] base_key;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    logic [CAP_W-1:0] cap;
    int               span;
    int               count;
    bit               one_bit_keys;

    store = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: key and value extremes, hit, miss, update, at reset capacity.
    send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_PUT, 32'h0000_0000, 32'h8000_0000);
    send_request(REQ_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_request(REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF);  // value ignored on get
    send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_GET, 32'h0000_0005, 32'h0000_0000);

    // Capacity zero acts as one, and it drops below the current fill: the
    // next new key evicts both entries, an update evicts nothing.
    write_capacity(5'd0);
    send_request(REQ_PUT, 32'h0000_0001, 32'h0000_0001);
    send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(REQ_GET, 32'h0000_0001, 32'h0000_0000);
    send_request(REQ_PUT, 32'h0000_0001, 32'h1234_5678);
    send_request(REQ_PUT, 32'h0000_0002, 32'h0000_0002);
    send_request(REQ_GET, 32'h0000_0001, 32'h0000_0000);
    send_request(REQ_GET, 32'h0000_0002, 32'h0000_0000);

    // All-ones capacity saturates; then a small table where a get reorders
    // recency and changes which key the next insertion evicts.
    write_capacity(5'd31);
    write_capacity(5'd3);
    send_request(REQ_PUT, 32'h0000_0010, 32'hAAAA_5555);
    send_request(REQ_PUT, 32'h0000_0011, 32'h5555_AAAA);
    send_request(REQ_PUT, 32'h0000_0012, 32'h0F0F_F0F0);
    send_request(REQ_GET, 32'h0000_0010, 32'h0000_0000);
    send_request(REQ_PUT, 32'h0000_0013, 32'hF0F0_0F0F);
    send_request(REQ_GET, 32'h0000_0011, 32'h0000_0000);
    send_request(REQ_GET, 32'h0000_0012, 32'h0000_0000);

    // Random phases. Keys come mostly from a small pool so that hits, updates
    // and evictions dominate; one key in ten is fresh noise. Each phase starts
    // with the fill left by the one before, so lowering the capacity forces
    // multi-entry evictions. The final phase runs without idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      one_bit_keys = 1'b0;
      case (p)
        0: begin cap = 5'd16; span = 20; count = 150; idle_pct = 20; end
        1: begin cap = 5'd1; span = 3; count = 100; idle_pct = 10; end
        2: begin cap = 5'd17; span = 22; count = 150; idle_pct = 30; end
        3: begin
          cap = 5'($urandom_range(2, 15)); span = cap + 3; count = 150; idle_pct = 10;
        end
        4: begin
          cap = 5'd5; span = 8; count = 120; idle_pct = 20; one_bit_keys = 1'b1;
        end
        default: begin
          cap = 5'($urandom_range(0, 31)); span = $urandom_range(2, 20); count = 150;
          idle_pct = 0;
        end
      endcase
      write_capacity(cap);
      // keys that each differ from a common base in one bit stress the key comparator
      base_key = $urandom();
      foreach (key_pool[i]) begin
        key_pool[i] = one_bit_keys ? base_key ^ (32'h1 << $urandom_range(0, 31))
                                   : $urandom();
      end
      repeat (count) begin
        key = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, span - 1)];
        case ($urandom_range(0, 7))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7FFF_FFFF;
          default: val = $urandom();
        endcase
        send_request($urandom_range(0, 1) ? REQ_PUT : REQ_GET, key, val);
      end
    end

    // Drain, then give the block time to show any stray result.
    in_valid_i <= 1'b0;
    while (store.pending() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (store.errors == 0 && store.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
